FILE: design/sit_pkg.sv
package sit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 2;
  localparam int NUM_W       = DIFF_W + CROSS_W + 1;
  localparam int THR_W       = 16;
  localparam int REL_W       = 3;
  localparam int DIV_STAGES  = COORD_WIDTH;
  localparam int FRONT_STAGES = 6;
  localparam int NUM_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

  typedef enum logic [REL_W-1:0] {
    REL_MISS     = 3'd0,
    REL_CROSS    = 3'd1,
    REL_OVERLAP  = 3'd2,
    REL_DISJOINT = 3'd3,
    REL_PARALLEL = 3'd4
  } relation_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;

  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
    diff_t  rx;
    diff_t  ry;
    diff_t  sx;
    diff_t  sy;
    diff_t  qx;
    diff_t  qy;
  } diff_stage_t;

  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
    diff_t  rx;
    diff_t  ry;
    prod_t  rx_sy;
    prod_t  ry_sx;
    prod_t  qx_ry;
    prod_t  qy_rx;
    prod_t  qx_sy;
    prod_t  qy_sx;
    prod_t  qx_rx;
    prod_t  qy_ry;
    prod_t  rx_rx;
    prod_t  ry_ry;
    prod_t  qx_sx;
    prod_t  qy_sy;
    prod_t  sx_sx;
    prod_t  sy_sy;
  } prod_stage_t;

  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
    diff_t  rx;
    diff_t  ry;
    cross_t rxs;
    cross_t qpxr;
    cross_t tn;
    cross_t dqr;
    cross_t rr;
    cross_t dps;
    cross_t ss;
  } sum_stage_t;

  typedef struct packed {
    coord_t    p1x;
    coord_t    p1y;
    diff_t     rx;
    diff_t     ry;
    cross_t    den;
    cross_t    tn;
    relation_t rel;
  } class_stage_t;

  typedef struct packed {
    logic signed [COORD_WIDTH+CROSS_W-1:0] pdx;
    logic signed [COORD_WIDTH+CROSS_W-1:0] pdy;
    logic signed [DIFF_W+CROSS_W-1:0]      dtx;
    logic signed [DIFF_W+CROSS_W-1:0]      dty;
    cross_t                                den;
    relation_t                             rel;
  } mul_stage_t;

  typedef struct packed {
    logic [NUM_W-1:0]       rem;
    logic [COORD_WIDTH-1:0] quo;
    logic                   neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t          lx;
    div_lane_t          ly;
    logic [CROSS_W-1:0] den;
    relation_t          rel;
  } div_stage_t;

  function automatic div_lane_t div_step(div_lane_t lane, logic [CROSS_W-1:0] den, int idx);
    div_lane_t        res;
    logic [NUM_W-1:0] sh;
    res = lane;
    sh  = NUM_W'(den) << idx;
    if (lane.rem >= sh) begin
      res.rem = lane.rem - sh;
      res.quo = lane.quo | (COORD_WIDTH'(1) << idx);
    end
    return res;
  endfunction

  function automatic div_lane_t div_load(logic signed [NUM_W-1:0] n);
    div_lane_t res;
    res.neg = n[NUM_W-1];
    res.rem = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    res.quo = '0;
    return res;
  endfunction

endpackage

FILE: design/segment_intersection_test.sv
// Segment intersection test: one pair of 2-D segments in, one result word out.
// Input channel in_valid/in_ready carries P1, P2 (first segment) and Q1, Q2
// (second segment) as signed Q11.4 coordinates. Output channel
// out_valid/out_ready carries meets, relation and the crossing point
// cross_x/cross_y (zero unless relation is crossing).
// cfg_we/cfg_wdata write zero_threshold; write it only while the block is empty.
// An accepted pair passes through 23 registers:
// six arithmetic stages (differences, products, cross and dot sums,
// classification, point numerator products, numerator sum) then a 16-stage
// restoring divider, one quotient bit per stage, then the output register.
// Throughput is one pair per cycle while out_ready is not stalling; every stage carries a valid bit.
// A stall on out_ready backs up only the full stages; bubbles are squeezed
// out so the input keeps being taken while any stage has room.
// Reset clears all valid bits and sets zero_threshold to 1.
module segment_intersection_test (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_start_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_start_y,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_end_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] first_end_y,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_start_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_start_y,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_end_x,
  input  logic signed [sit_pkg::COORD_WIDTH-1:0] second_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            meets,
  output logic [sit_pkg::REL_W-1:0]       relation,
  output logic signed [sit_pkg::COORD_WIDTH-1:0] cross_x,
  output logic signed [sit_pkg::COORD_WIDTH-1:0] cross_y,
  input  logic                            cfg_we,
  input  logic [sit_pkg::THR_W-1:0]       cfg_wdata
);

  localparam int NS = sit_pkg::NUM_STAGES;
  localparam int FS = sit_pkg::FRONT_STAGES;
  localparam int CW = sit_pkg::COORD_WIDTH;
  localparam int XW = sit_pkg::CROSS_W;
  localparam int NW = sit_pkg::NUM_W;

  logic [sit_pkg::THR_W-1:0] zero_threshold;
  logic [NS-1:0]             vld;
  logic [NS:0]               adv;

  sit_pkg::diff_stage_t  s1, s1_next;
  sit_pkg::prod_stage_t  s2, s2_next;
  sit_pkg::sum_stage_t   s3, s3_next;
  sit_pkg::class_stage_t s4, s4_next;
  sit_pkg::mul_stage_t   s5, s5_next;
  sit_pkg::div_stage_t   s6, s6_next;
  sit_pkg::div_stage_t   dv [sit_pkg::DIV_STAGES];

  logic                        meets_next;
  logic [sit_pkg::REL_W-1:0]   relation_next;
  logic signed [CW-1:0]        cross_x_next;
  logic signed [CW-1:0]        cross_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= sit_pkg::THR_W'(1);
    end else if (cfg_we) begin
      zero_threshold <= cfg_wdata;
    end
  end

  // stage k advances when empty or when the stage after it advances
  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    s1_next.p1x = first_start_x;
    s1_next.p1y = first_start_y;
    s1_next.rx  = sit_pkg::DIFF_W'(first_end_x) - sit_pkg::DIFF_W'(first_start_x);
    s1_next.ry  = sit_pkg::DIFF_W'(first_end_y) - sit_pkg::DIFF_W'(first_start_y);
    s1_next.sx  = sit_pkg::DIFF_W'(second_end_x) - sit_pkg::DIFF_W'(second_start_x);
    s1_next.sy  = sit_pkg::DIFF_W'(second_end_y) - sit_pkg::DIFF_W'(second_start_y);
    s1_next.qx  = sit_pkg::DIFF_W'(second_start_x) - sit_pkg::DIFF_W'(first_start_x);
    s1_next.qy  = sit_pkg::DIFF_W'(second_start_y) - sit_pkg::DIFF_W'(first_start_y);
  end

  always_comb begin
    s2_next.p1x   = s1.p1x;
    s2_next.p1y   = s1.p1y;
    s2_next.rx    = s1.rx;
    s2_next.ry    = s1.ry;
    s2_next.rx_sy = s1.rx * s1.sy;
    s2_next.ry_sx = s1.ry * s1.sx;
    s2_next.qx_ry = s1.qx * s1.ry;
    s2_next.qy_rx = s1.qy * s1.rx;
    s2_next.qx_sy = s1.qx * s1.sy;
    s2_next.qy_sx = s1.qy * s1.sx;
    s2_next.qx_rx = s1.qx * s1.rx;
    s2_next.qy_ry = s1.qy * s1.ry;
    s2_next.rx_rx = s1.rx * s1.rx;
    s2_next.ry_ry = s1.ry * s1.ry;
    s2_next.qx_sx = s1.qx * s1.sx;
    s2_next.qy_sy = s1.qy * s1.sy;
    s2_next.sx_sx = s1.sx * s1.sx;
    s2_next.sy_sy = s1.sy * s1.sy;
  end

  always_comb begin
    s3_next.p1x  = s2.p1x;
    s3_next.p1y  = s2.p1y;
    s3_next.rx   = s2.rx;
    s3_next.ry   = s2.ry;
    s3_next.rxs  = XW'(s2.rx_sy) - XW'(s2.ry_sx);
    s3_next.qpxr = XW'(s2.qx_ry) - XW'(s2.qy_rx);
    s3_next.tn   = XW'(s2.qx_sy) - XW'(s2.qy_sx);
    s3_next.dqr  = XW'(s2.qx_rx) + XW'(s2.qy_ry);
    s3_next.rr   = XW'(s2.rx_rx) + XW'(s2.ry_ry);
    s3_next.dps  = -(XW'(s2.qx_sx) + XW'(s2.qy_sy));
    s3_next.ss   = XW'(s2.sx_sx) + XW'(s2.sy_sy);
  end

  logic [XW-1:0]          thr;
  logic [XW-1:0]          abs_rxs;
  logic [XW-1:0]          abs_qpxr;
  logic                   rz;
  logic                   qz;
  logic                   ov;
  logic signed [XW-1:0]   tn_adj;
  logic signed [XW-1:0]   un_adj;

  always_comb begin
    thr      = (zero_threshold == '0) ? XW'(1) : XW'(zero_threshold);
    abs_rxs  = s3.rxs[XW-1] ? XW'(-s3.rxs) : XW'(s3.rxs);
    abs_qpxr = s3.qpxr[XW-1] ? XW'(-s3.qpxr) : XW'(s3.qpxr);
    rz       = abs_rxs < thr;
    qz       = abs_qpxr < thr;
    ov       = (!s3.dqr[XW-1] && (s3.dqr <= s3.rr)) || (!s3.dps[XW-1] && (s3.dps <= s3.ss));
    tn_adj   = s3.rxs[XW-1] ? -s3.tn : s3.tn;
    un_adj   = s3.rxs[XW-1] ? -s3.qpxr : s3.qpxr;
    s4_next.p1x = s3.p1x;
    s4_next.p1y = s3.p1y;
    s4_next.rx  = s3.rx;
    s4_next.ry  = s3.ry;
    s4_next.den = $signed(abs_rxs);
    s4_next.tn  = tn_adj;
    if (rz && qz) begin
      s4_next.rel = ov ? sit_pkg::REL_OVERLAP : sit_pkg::REL_DISJOINT;
    end else if (rz) begin
      s4_next.rel = sit_pkg::REL_PARALLEL;
    end else if (!tn_adj[XW-1] && (tn_adj <= $signed(abs_rxs)) &&
                 !un_adj[XW-1] && (un_adj <= $signed(abs_rxs))) begin
      s4_next.rel = sit_pkg::REL_CROSS;
    end else begin
      s4_next.rel = sit_pkg::REL_MISS;
    end
  end

  always_comb begin
    s5_next.pdx = s4.p1x * s4.den;
    s5_next.pdy = s4.p1y * s4.den;
    s5_next.dtx = s4.rx * s4.tn;
    s5_next.dty = s4.ry * s4.tn;
    s5_next.den = s4.den;
    s5_next.rel = s4.rel;
  end

  always_comb begin
    s6_next.lx  = sit_pkg::div_load(NW'(s5.pdx) + NW'(s5.dtx));
    s6_next.ly  = sit_pkg::div_load(NW'(s5.pdy) + NW'(s5.dty));
    s6_next.den = XW'(s5.den);
    s6_next.rel = s5.rel;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s1 <= s1_next;
    if (adv[1]) s2 <= s2_next;
    if (adv[2]) s3 <= s3_next;
    if (adv[3]) s4 <= s4_next;
    if (adv[4]) s5 <= s5_next;
    if (adv[5]) s6 <= s6_next;
  end

  for (genvar j = 0; j < sit_pkg::DIV_STAGES; j++) begin : g_div
    sit_pkg::div_stage_t src;
    sit_pkg::div_stage_t dst;
    if (j == 0) begin : g_first
      assign src = s6;
    end else begin : g_rest
      assign src = dv[j-1];
    end
    always_comb begin
      dst     = src;
      dst.lx  = sit_pkg::div_step(src.lx, src.den, CW - 1 - j);
      dst.ly  = sit_pkg::div_step(src.ly, src.den, CW - 1 - j);
    end
    always_ff @(posedge clk) begin
      if (adv[FS+j]) begin
        dv[j] <= dst;
      end
    end
  end

  always_comb begin
    sit_pkg::div_stage_t last;
    last          = dv[sit_pkg::DIV_STAGES-1];
    relation_next = last.rel;
    meets_next    = (last.rel == sit_pkg::REL_CROSS) || (last.rel == sit_pkg::REL_OVERLAP);
    if (last.rel == sit_pkg::REL_CROSS) begin
      cross_x_next = last.lx.neg ? -$signed(last.lx.quo) : $signed(last.lx.quo);
      cross_y_next = last.ly.neg ? -$signed(last.ly.quo) : $signed(last.ly.quo);
    end else begin
      cross_x_next = '0;
      cross_y_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      meets    <= meets_next;
      relation <= relation_next;
      cross_x  <= cross_x_next;
      cross_y  <= cross_y_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_meets_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (meets == ((relation == sit_pkg::REL_CROSS) ||
                             (relation == sit_pkg::REL_OVERLAP))))
    else $error("meets disagrees with relation");

  a_point_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (relation != sit_pkg::REL_CROSS) |-> (cross_x == '0) && (cross_y == '0))
    else $error("nonzero point without crossing");

  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    vld[FS-1] && (s6.rel == sit_pkg::REL_CROSS) |->
      (s6.lx.rem < (NW'(s6.den) << CW)) && (s6.ly.rem < (NW'(s6.den) << CW)))
    else $error("crossing numerator exceeds quotient range");
`endif

endmodule

FILE: test/segment_intersection_test_tb.sv
`timescale 1ns / 1ps

module segment_intersection_test_tb;

  typedef struct {
    logic signed [15:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
  } seg_pair_t;

  typedef struct {
    logic               meets;
    sit_pkg::relation_t rel;
    logic signed [15:0] cx, cy;
  } hit_t;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] first_start_x = '0, first_start_y = '0;
  logic signed [15:0] first_end_x = '0, first_end_y = '0;
  logic signed [15:0] second_start_x = '0, second_start_y = '0;
  logic signed [15:0] second_end_x = '0, second_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic meets;
  logic [sit_pkg::REL_W-1:0] relation;
  logic signed [15:0] cross_x, cross_y;
  logic cfg_we = 1'b0;
  logic [sit_pkg::THR_W-1:0] cfg_wdata = '0;

  seg_pair_t pair_q[$];
  hit_t hit_q[$];
  logic [15:0] threshold = 16'd1;
  int mismatches = 0;
  int idle_cycles = 0;
  int holdoff = 0;
  bit calm = 1'b0;
  bit timed_out = 1'b0;

  always #1 clk = ~clk;

  segment_intersection_test u_top (
    .clk, .rst, .in_valid, .in_ready,
    .first_start_x, .first_start_y, .first_end_x, .first_end_y,
    .second_start_x, .second_start_y, .second_end_x, .second_end_y,
    .out_valid, .out_ready, .meets, .relation, .cross_x, .cross_y,
    .cfg_we, .cfg_wdata
  );

  function automatic bit is_flat(longint v);
    longint th;
    th = (threshold == 0) ? 1 : longint'(threshold);
    return ((v < 0) ? -v : v) < th;
  endfunction

  function automatic logic signed [15:0] point_at(longint p, longint d, longint tn,
                                                  longint den);
    logic signed [127:0] n, q;
    n = 128'(p) * 128'(den) + 128'(d) * 128'(tn);
    q = n / 128'(den);
    return q[15:0];
  endfunction

  function automatic hit_t classify(seg_pair_t s);
    hit_t h;
    longint rx, ry, sx, sy, qx, qy, rxs, qpxr, tn, den, un, dqr, rr, dps, ss;
    rx = s.p2x - s.p1x; ry = s.p2y - s.p1y;
    sx = s.q2x - s.q1x; sy = s.q2y - s.q1y;
    qx = s.q1x - s.p1x; qy = s.q1y - s.p1y;
    rxs = rx * sy - ry * sx;
    qpxr = qx * ry - qy * rx;
    h.rel = sit_pkg::REL_MISS; h.cx = '0; h.cy = '0;
    if (is_flat(rxs) && is_flat(qpxr)) begin
      dqr = qx * rx + qy * ry; rr = rx * rx + ry * ry;
      dps = -(qx * sx + qy * sy); ss = sx * sx + sy * sy;
      h.rel = ((dqr >= 0 && dqr <= rr) || (dps >= 0 && dps <= ss)) ?
              sit_pkg::REL_OVERLAP : sit_pkg::REL_DISJOINT;
    end else if (is_flat(rxs)) begin
      h.rel = sit_pkg::REL_PARALLEL;
    end else begin
      den = rxs; tn = qx * sy - qy * sx; un = qpxr;
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
        h.rel = sit_pkg::REL_CROSS;
        h.cx = point_at(s.p1x, rx, tn, den);
        h.cy = point_at(s.p1y, ry, tn, den);
      end
    end
    h.meets = (h.rel == sit_pkg::REL_CROSS || h.rel == sit_pkg::REL_OVERLAP);
    return h;
  endfunction

  function automatic logic signed [15:0] rnd_coord(int span);
    if (span >= 32768) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic seg_pair_t rnd_pair(int span, int kind);
    seg_pair_t s;
    int k;
    s.p1x = rnd_coord(span); s.p1y = rnd_coord(span);
    s.p2x = rnd_coord(span); s.p2y = rnd_coord(span);
    s.q1x = rnd_coord(span); s.q1y = rnd_coord(span);
    s.q2x = rnd_coord(span); s.q2y = rnd_coord(span);
    if (kind == 1 || kind == 2) begin
      // place Q on the line through P, or on a shifted copy of it
      k = $urandom_range(6);
      s.p2x = s.p1x + 16'($signed(k) - 3) * 16'sd5;
      s.p2y = s.p1y + 16'($signed(k) - 3) * 16'sd3;
      k = $signed($urandom_range(40)) - 20;
      s.q1x = s.p1x + 16'(k * 5) + ((kind == 2) ? 16'sd1 : 16'sd0);
      s.q1y = s.p1y + 16'(k * 3);
      k = $signed($urandom_range(40)) - 20;
      s.q2x = s.q1x + 16'(k * 5);
      s.q2y = s.q1y + 16'(k * 3);
    end
    return s;
  endfunction

  task automatic push(logic signed [15:0] a, b, c, d, e, f, g, h);
    seg_pair_t s;
    s.p1x = a; s.p1y = b; s.p2x = c; s.p2y = d;
    s.q1x = e; s.q1y = f; s.q2x = g; s.q2y = h;
    pair_q.push_back(s);
  endtask

  task automatic set_threshold(logic [15:0] v);
    while (pair_q.size() != 0 || in_valid || hit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    threshold = v;
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) hit_q.push_back(classify('{first_start_x, first_start_y,
          first_end_x, first_end_y, second_start_x, second_start_y,
          second_end_x, second_end_y}));
      if (pair_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
        seg_pair_t s;
        s = pair_q.pop_front();
        in_valid <= 1'b1;
        first_start_x <= s.p1x; first_start_y <= s.p1y;
        first_end_x <= s.p2x; first_end_y <= s.p2y;
        second_start_x <= s.q1x; second_start_y <= s.q1y;
        second_end_x <= s.q2x; second_end_y <= s.q2y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holdoff > 0) begin
      holdoff <= holdoff - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 23;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: rel=%0d", relation);
      end else begin
        hit_t e;
        e = hit_q.pop_front();
        if (meets !== e.meets || relation !== e.rel || cross_x !== e.cx ||
            cross_y !== e.cy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp m=%0b r=%0d (%0d,%0d) got m=%0b r=%0d (%0d,%0d)",
                     e.meets, e.rel, e.cx, e.cy, meets, relation, cross_x, cross_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("segment_intersection_test_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    push(0, 0, 160, 160, 0, 160, 160, 0);
    push(0, 0, 160, 0, 32, 0, 320, 0);
    push(0, 0, 160, 0, 320, 0, 480, 0);
    push(0, 0, 160, 0, 0, 16, 160, 16);
    push(0, 0, 160, 0, 200, -16, 200, 16);
    push(5, 5, 5, 5, 5, 5, 5, 5);
    push(5, 5, 5, 5, 9, 9, 9, 9);
    push(0, 0, 160, 0, 160, 0, 160, 80);
    push(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    push(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    push(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    push(-1, -1, 1, 1, -1, 1, 1, -1);
    push(0, 0, 3, 1, 0, 1, 3, 0);
    push(-7, 3, 11, -5, 2, -9, -4, 13);
    for (int i = 0; i < 6; i++) pair_q.push_back(rnd_pair(32768, 0));
    set_threshold(16'd0);
    push(0, 0, 3, 1, 6, 2, 9, 3);
    push(0, 0, 3, 1, 6, 3, 9, 4);
    set_threshold(16'hFFFF);
    for (int i = 0; i < 4; i++) pair_q.push_back(rnd_pair(100, 0));
    set_threshold(16'd1);
    calm = 1'b1;
    for (int i = 0; i < 120; i++) pair_q.push_back(rnd_pair(32768, 0));
    while (pair_q.size() > 80) @(posedge clk);
    calm = 1'b0;
    holdoff = 300;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_threshold(16'd1);
        1: set_threshold(16'd0);
        2: set_threshold(16'($urandom_range(200, 2)));
        default: set_threshold(16'hFFFF);
      endcase
      for (int i = 0; i < 100; i++)
        pair_q.push_back(rnd_pair((i % 3 == 0) ? 32768 : 200, $urandom_range(3)));
    end
    while (pair_q.size() != 0 || in_valid || hit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("segment_intersection_test_tb: clean");
    end else begin
      $display("segment_intersection_test_tb: errors");
    end
    $finish;
  end
endmodule
